/* design/lut_tree_cover_cost_select_macros.svh */
// ---------------------------------------------------------------------------
// LUT tree cover cost select: assertion macros
// Shorthand for the clocked checks used by the port checker.
// ---------------------------------------------------------------------------
`ifndef LUT_TREE_COVER_COST_SELECT_MACROS_SVH
`define LUT_TREE_COVER_COST_SELECT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LTCC_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ltcc check failed");

// Next-cycle implication, disabled while reset is high.
`define LTCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ltcc check failed");

// Next-cycle implication that also holds across reset.
`define LTCC_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ltcc check failed");

`endif

/* design/ltcc_pkg.sv */
// ---------------------------------------------------------------------------
// LUT tree cover cost select: shared package
// Field widths, opcodes, table write bundle and node slot reduction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package ltcc_pkg;

  localparam int unsigned ID_W      = 12;
  localparam int unsigned ID_SPAN   = 4096;
  localparam int unsigned SIZE_W    = 3;
  localparam int unsigned MASK_W    = 6;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned COST_W    = 16;
  localparam int unsigned MAX_LANES = 6;

  localparam logic [COST_W-1:0] COST_MAX = '1;

  typedef enum logic {
    OP_PI  = 1'b0,
    OP_CUT = 1'b1
  } op_t;

  // One write into the replicated cost tables.
  typedef struct packed {
    logic              en;
    logic [ID_W-1:0]   slot;
    logic [COST_W-1:0] cost;
  } tbl_wr_t;

  // Control for the running minimum in the merge stage.
  typedef struct packed {
    logic en;
    logic last;
  } step_t;

  // Reduces an id modulo the table span by restoring subtraction. For a span of
  // at least 16, a 12-bit id needs no more than eight steps.
  function automatic logic [ID_W-1:0] node_slot(input logic [ID_W-1:0] id,
                                                 input int unsigned span);
    logic [31:0] r;
    logic [31:0] d;
    r = 32'(id);
    for (int k = 7; k >= 0; k--) begin
      d = 32'(span) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return r[ID_W-1:0];
  endfunction

endpackage

/* design/ltcc_if.sv */
// ---------------------------------------------------------------------------
// LUT tree cover cost select: channel interfaces
// Valid/ready channels for cut beats in and cover result beats out.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface ltcc_in_if import ltcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [ID_W-1:0]   node_id;
  logic [SIZE_W-1:0] cut_size;
  logic [ID_W-1:0]   leaf_a;
  logic [ID_W-1:0]   leaf_b;
  logic [ID_W-1:0]   leaf_c;
  logic [ID_W-1:0]   leaf_d;
  logic [ID_W-1:0]   leaf_e;
  logic [ID_W-1:0]   leaf_f;
  logic [MASK_W-1:0] single_fanout_mask;
  logic              last_cut;

  modport source(output valid, op, node_id, cut_size, leaf_a, leaf_b, leaf_c, leaf_d,
                 leaf_e, leaf_f, single_fanout_mask, last_cut, input ready);
  modport sink(input valid, op, node_id, cut_size, leaf_a, leaf_b, leaf_c, leaf_d,
               leaf_e, leaf_f, single_fanout_mask, last_cut, output ready);
endinterface

interface ltcc_out_if import ltcc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   out_node;
  logic              has_cut;
  logic [IDX_W-1:0]  best_cut_index;
  logic [COST_W-1:0] best_cost;

  modport source(output valid, out_node, has_cut, best_cut_index, best_cost, input ready);
  modport sink(input valid, out_node, has_cut, best_cut_index, best_cost, output ready);
endinterface

/* design/lut_tree_cover_cost_select.sv */
// ---------------------------------------------------------------------------
// LUT tree cover cost select: top level
// Area-oriented tree covering cost selection for LUT mapping.
// ---------------------------------------------------------------------------
// Usage. Beats arrive on cut_in in topological node order. A primary-input
// beat (op = 0) sets the node's cost to zero and yields one result beat with
// has_cut low. A cut beat (op = 1) is one cut of a logic node; its cost is one
// plus the stored costs of its leaves flagged in single_fanout_mask. On the
// node's last cut a result beat on cover_out carries the smallest cost and the
// position of the first cut that reached it, and that cost is stored.
// Throughput is one beat per cycle unless the receiver stalls. Each leaf lane
// holds its own copy of the cost table, so all leaves are looked up in the
// cycle of acceptance; a beat writes at most one entry, so one write port per
// copy is enough. A beat waits in the merge stage registers until the result
// register is free. When the receiver stalls, a held result keeps its
// payload, the stage behind it fills, and then cut_in.ready drops. Reset
// clears the pipeline valids and the running minimum at once; the cost table
// holds no reset value, and no clearing pass is run.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lut_tree_cover_cost_select import ltcc_pkg::*; #(
  parameter int unsigned NODE_COUNT = 4096,
  parameter int unsigned LUT_INPUTS = 6,
  parameter int unsigned MAX_CUTS   = 64
) (
  input logic       clk,
  input logic       rst,
  ltcc_in_if.sink   cut_in,
  ltcc_out_if.source cover_out
);

  // Accept and lookup stage.
  logic                  accept;
  logic [ID_W-1:0]       leaf [MAX_LANES];
  logic [LUT_INPUTS-1:0] use_next;
  logic [ID_W-1:0]       slot_next;

  // Merge stage registers.
  logic                  s1_valid;
  logic                  s1_op;
  logic [ID_W-1:0]       s1_node;
  logic [ID_W-1:0]       s1_slot;
  logic                  s1_last;
  logic [LUT_INPUTS-1:0] s1_use;
  logic                  s1_adv;
  logic                  s1_emit;

  // Result register.
  logic                  out_valid;
  logic [ID_W-1:0]       out_node;
  logic                  out_has_cut;
  logic [IDX_W-1:0]      out_idx;
  logic [COST_W-1:0]     out_cost;

  logic [COST_W-1:0]     contrib [LUT_INPUTS];
  logic [COST_W-1:0]     merge_cost;
  logic [IDX_W-1:0]      merge_idx;
  tbl_wr_t               wr;
  step_t                 step;

  assign leaf[0] = cut_in.leaf_a;
  assign leaf[1] = cut_in.leaf_b;
  assign leaf[2] = cut_in.leaf_c;
  assign leaf[3] = cut_in.leaf_d;
  assign leaf[4] = cut_in.leaf_e;
  assign leaf[5] = cut_in.leaf_f;

  // The merge stage moves on whenever the result register is empty or drains.
  assign s1_adv       = s1_valid && (!out_valid || cover_out.ready);
  assign cut_in.ready = !s1_valid || s1_adv;
  assign accept       = cut_in.valid && cut_in.ready;
  assign slot_next    = node_slot(cut_in.node_id, NODE_COUNT);

  // A leaf counts only if it lies inside the cut and has a single fanout.
  always_comb begin
    for (int i = 0; i < int'(LUT_INPUTS); i++) begin
      use_next[i] = cut_in.single_fanout_mask[i] && (SIZE_W'(i) < cut_in.cut_size);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op   <= cut_in.op;
      s1_node <= cut_in.node_id;
      s1_slot <= slot_next;
      s1_last <= cut_in.last_cut;
      s1_use  <= use_next;
    end
  end

  for (genvar g = 0; g < int'(LUT_INPUTS); g++) begin : g_lane
    ltcc_lane #(
      .NODE_COUNT(NODE_COUNT)
    ) u_lane (
      .clk    (clk),
      .rst    (rst),
      .rd_en  (accept),
      .rd_slot(node_slot(leaf[g], NODE_COUNT)),
      .use_bit(s1_use[g]),
      .wr     (wr),
      .contrib(contrib[g])
    );
  end

  assign step.en   = s1_adv && (s1_op == OP_CUT);
  assign step.last = s1_last;

  ltcc_merge #(
    .LUT_INPUTS(LUT_INPUTS),
    .MAX_CUTS  (MAX_CUTS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .contrib   (contrib),
    .step      (step),
    .best_cost (merge_cost),
    .best_index(merge_idx)
  );

  // A primary input or a node's last cut both produce a beat and a table write.
  assign s1_emit = (s1_op == OP_PI) || s1_last;
  assign wr.en   = s1_adv && s1_emit;
  assign wr.slot = s1_slot;
  assign wr.cost = (s1_op == OP_PI) ? '0 : merge_cost;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_emit) begin
      out_valid <= 1'b1;
    end else if (cover_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_emit) begin
      out_node    <= s1_node;
      out_has_cut <= (s1_op == OP_CUT);
      out_idx     <= (s1_op == OP_PI) ? '0 : merge_idx;
      out_cost    <= wr.cost;
    end
  end

  assign cover_out.valid          = out_valid;
  assign cover_out.out_node       = out_node;
  assign cover_out.has_cut        = out_has_cut;
  assign cover_out.best_cut_index = out_idx;
  assign cover_out.best_cost      = out_cost;

endmodule

/* design/ltcc_lane.sv */
// ---------------------------------------------------------------------------
// LUT tree cover cost select: leaf lane
// One copy of the node cost table, read at one leaf, with write bypass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ltcc_lane import ltcc_pkg::*; #(
  parameter int unsigned NODE_COUNT = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              rd_en,
  input  logic [ID_W-1:0]   rd_slot,
  input  logic              use_bit,
  input  tbl_wr_t           wr,
  output logic [COST_W-1:0] contrib
);

  localparam int unsigned DEPTH = (NODE_COUNT < ID_SPAN) ? NODE_COUNT : ID_SPAN;
  localparam int unsigned AW    = $clog2(DEPTH);

  logic [COST_W-1:0] mem [DEPTH];
  logic [COST_W-1:0] rd_data;
  logic [ID_W-1:0]   rd_slot_q;
  tbl_wr_t           fwd;
  logic              hit;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.slot[AW-1:0]] <= wr.cost;
    end
    if (rd_en) begin
      rd_data   <= mem[rd_slot[AW-1:0]];
      rd_slot_q <= rd_slot;
    end
  end

  // The latest write is kept so a read issued on the same edge sees it.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd.en <= 1'b0;
    end else if (wr.en) begin
      fwd <= wr;
    end
  end

  assign hit     = fwd.en && (fwd.slot == rd_slot_q);
  assign contrib = !use_bit ? '0 : (hit ? fwd.cost : rd_data);

endmodule

/* design/ltcc_merge.sv */
// ---------------------------------------------------------------------------
// LUT tree cover cost select: merge stage
// Sums the lane costs and tracks the running minimum over a node's cuts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module ltcc_merge import ltcc_pkg::*; #(
  parameter int unsigned LUT_INPUTS = 6,
  parameter int unsigned MAX_CUTS   = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [COST_W-1:0] contrib [LUT_INPUTS],
  input  step_t             step,
  output logic [COST_W-1:0] best_cost,
  output logic [IDX_W-1:0]  best_index
);

  localparam int unsigned SUM_W   = COST_W + $clog2(LUT_INPUTS + 1);
  localparam int unsigned IDX_TOP = (1 << IDX_W) - 1;
  localparam int unsigned LIM_RAW = MAX_CUTS - 1;
  localparam int unsigned CNT_LIM = (LIM_RAW > IDX_TOP) ? IDX_TOP : LIM_RAW;

  logic [SUM_W-1:0]  sum;
  logic [COST_W-1:0] cost;
  logic              better;
  logic [COST_W-1:0] run_min;
  logic [IDX_W-1:0]  run_idx;
  logic [IDX_W-1:0]  cnt;

  always_comb begin
    sum = SUM_W'(1);
    for (int i = 0; i < int'(LUT_INPUTS); i++) begin
      sum = sum + SUM_W'(contrib[i]);
    end
    cost = (sum > SUM_W'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
  end

  // Only a strictly smaller cost wins, so the first best cut is kept.
  assign better     = cost < run_min;
  assign best_cost  = better ? cost : run_min;
  assign best_index = better ? cnt : run_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_min <= COST_MAX;
      run_idx <= '0;
      cnt     <= '0;
    end else if (step.en) begin
      if (step.last) begin
        run_min <= COST_MAX;
        run_idx <= '0;
        cnt     <= '0;
      end else begin
        run_min <= best_cost;
        run_idx <= best_index;
        if (cnt < IDX_W'(CNT_LIM)) begin
          cnt <= cnt + 1'b1;
        end
      end
    end
  end

endmodule

/* design/ltcc_checker.sv */
// ---------------------------------------------------------------------------
// LUT tree cover cost select: port checker
// Watches the top-level ports for handshake and result sanity.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lut_tree_cover_cost_select_macros.svh"

module ltcc_checker import ltcc_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ID_W-1:0]   out_node,
  input logic              has_cut,
  input logic [IDX_W-1:0]  best_cut_index,
  input logic [COST_W-1:0] best_cost
);

  `LTCC_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  `LTCC_ASSERT_NEXT(a_out_stable, clk, rst, out_valid && !out_ready, $stable(out_node) && $stable(has_cut) && $stable(best_cut_index) && $stable(best_cost))
  `LTCC_ASSERT_NEXT_ALWAYS(a_reset_idle, clk, rst, !out_valid && in_ready)
  `LTCC_ASSERT_NOW(a_stall_cause, clk, rst, !in_ready, out_valid && !out_ready)
  `LTCC_ASSERT_NOW(a_logic_cost, clk, rst, out_valid && has_cut, best_cost != '0)

endmodule

bind lut_tree_cover_cost_select ltcc_checker u_ltcc_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (cut_in.ready),
  .out_valid     (cover_out.valid),
  .out_ready     (cover_out.ready),
  .out_node      (cover_out.out_node),
  .has_cut       (cover_out.has_cut),
  .best_cut_index(cover_out.best_cut_index),
  .best_cost     (cover_out.best_cost)
);
